// File: hdl/crpd_pkg.sv
// Package for the pinhole camera primary ray block: widths, register codes,
// configuration and queue entry types, component extraction helpers.
// Depends on nothing; every other file imports it.
package crpd_pkg;

	localparam int MaxDim    = 4096;
	localparam int CompBits  = 20;
	localparam int DimW      = 13;
	localparam int PixW      = 12;
	localparam int ScaleW    = 24;
	localparam int VecW      = 3 * CompBits;
	localparam int OfsW      = 14;
	localparam int MagW      = 58;
	localparam int NrmW      = 30;
	localparam int RootW     = 64;
	localparam int RootIters = 32;
	localparam int QuoW      = 17;
	localparam int NumW      = 47;
	localparam int OutW      = 18;
	localparam int AddrW     = 6;
	localparam int DataW     = 64;
	localparam int QDepth    = 4;
	localparam int QPtrW     = 2;

	localparam logic [DimW-1:0]   RstWidth  = 13'd512;
	localparam logic [DimW-1:0]   RstHeight = 13'd512;
	localparam logic [ScaleW-1:0] RstScale  = 24'd1182;
	localparam logic [VecW-1:0]   RstFwd    = 60'd864691128455135232;
	localparam logic [VecW-1:0]   RstRight  = 60'd262144;
	localparam logic [VecW-1:0]   RstUp     = 60'd274877906944;

	typedef enum logic [2:0] {
		REG_WIDTH   = 3'd0,
		REG_HEIGHT  = 3'd1,
		REG_SCALE   = 3'd2,
		REG_FORWARD = 3'd3,
		REG_RIGHT   = 3'd4,
		REG_UP      = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [DimW-1:0]   width;
		logic [DimW-1:0]   height;
		logic [ScaleW-1:0] scale;
		logic [VecW-1:0]   fwd;
		logic [VecW-1:0]   right;
		logic [VecW-1:0]   up;
	} cfg_t;

	typedef struct packed {
		logic signed [OfsW-1:0] tx;
		logic signed [OfsW-1:0] ty;
	} ofs_t;

	typedef struct packed {
		logic       zero;
		logic [2:0] neg;
	} tag_t;

	function automatic logic signed [CompBits-1:0] comp_of(input logic [VecW-1:0] v,
		input logic [1:0] k);
		logic [VecW-1:0] sh;
		sh = v >> (k * CompBits);
		return $signed(sh[CompBits-1:0]);
	endfunction

	function automatic logic [DimW-1:0] sat_dim(input logic [DimW-1:0] v);
		return (v > DimW'(MaxDim)) ? DimW'(MaxDim) : v;
	endfunction

	function automatic logic [2:0] lz8(input logic [7:0] b);
		logic [2:0] n;
		n = 3'd7;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) n = 3'(7 - i);
		end
		return n;
	endfunction

endpackage

// File: hdl/camera_primary_ray_direction.sv
// Pinhole camera primary ray direction, top level.
// Throughput: one ray per cycle while out_stall does not hold the output
// register; set by the fully pipelined back end (32-stage root and 17-stage
// divider, one step a stage).
// Reset: asynchronous, clears queue and pipeline valids, loads register defaults.
// Uses crpd_pkg, crpd_regs, crpd_front, crpd_queue, crpd_back.
module camera_primary_ray_direction import crpd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [AddrW-1:0]       paddr,
	input  logic [DataW-1:0]       pwdata,
	output logic [DataW-1:0]       prdata,
	output logic                   pready,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [PixW-1:0]        pixel_col,
	input  logic [PixW-1:0]        pixel_row,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [OutW-1:0] dir_x,
	output logic signed [OutW-1:0] dir_y,
	output logic signed [OutW-1:0] dir_z
);

	cfg_t cfg;
	ofs_t ofs;
	ofs_t head;
	logic push, pop, q_full, q_empty;

	crpd_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	crpd_front u_front (
		.in_valid, .in_stall, .pixel_col, .pixel_row,
		.width(cfg.width), .height(cfg.height), .q_full, .push, .ofs
	);

	crpd_queue u_queue (
		.clk, .arst_n, .push, .wdata(ofs), .pop, .head,
		.full(q_full), .empty(q_empty)
	);

	crpd_back u_back (
		.clk, .arst_n, .cfg, .head, .q_empty, .pop,
		.out_valid, .out_stall, .dir_x, .dir_y, .dir_z
	);

endmodule

// File: hdl/crpd_regs.sv
// APB-style configuration registers of the primary ray block.
// Depends on crpd_pkg for the register codes and the configuration struct.
module crpd_regs import crpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	cfg_t cfg_q;
	logic wr;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[AddrW-1:3]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= RstWidth;
			cfg_q.height <= RstHeight;
			cfg_q.scale  <= RstScale;
			cfg_q.fwd    <= RstFwd;
			cfg_q.right  <= RstRight;
			cfg_q.up     <= RstUp;
		end else if (wr) begin
			unique case (idx)
				REG_WIDTH:   cfg_q.width  <= pwdata[DimW-1:0];
				REG_HEIGHT:  cfg_q.height <= pwdata[DimW-1:0];
				REG_SCALE:   cfg_q.scale  <= pwdata[ScaleW-1:0];
				REG_FORWARD: cfg_q.fwd    <= pwdata[VecW-1:0];
				REG_RIGHT:   cfg_q.right  <= pwdata[VecW-1:0];
				REG_UP:      cfg_q.up     <= pwdata[VecW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WIDTH:   prdata = DataW'(cfg_q.width);
			REG_HEIGHT:  prdata = DataW'(cfg_q.height);
			REG_SCALE:   prdata = DataW'(cfg_q.scale);
			REG_FORWARD: prdata = DataW'(cfg_q.fwd);
			REG_RIGHT:   prdata = DataW'(cfg_q.right);
			REG_UP:      prdata = DataW'(cfg_q.up);
			default:     prdata = '0;
		endcase
	end

endmodule

// File: hdl/crpd_front.sv
// Front end: accepts pixel transfers and forms the integer screen offsets.
// Depends on crpd_pkg; feeds crpd_queue.
module crpd_front import crpd_pkg::*; (
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [PixW-1:0] pixel_col,
	input  logic [PixW-1:0] pixel_row,
	input  logic [DimW-1:0] width,
	input  logic [DimW-1:0] height,
	input  logic            q_full,
	output logic            push,
	output ofs_t            ofs
);

	logic [DimW-1:0] w_sat;
	logic [DimW-1:0] h_sat;

	assign w_sat    = sat_dim(width);
	assign h_sat    = sat_dim(height);
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// 2c+1-W and H-2r-1
	assign ofs.tx = $signed({1'b0, pixel_col, 1'b1}) - $signed({1'b0, w_sat});
	assign ofs.ty = $signed({1'b0, h_sat}) - $signed({1'b0, pixel_row, 1'b1});

endmodule

// File: hdl/crpd_queue.sv
// Short queue of screen offsets between the front end and the arithmetic back end.
// Depends on crpd_pkg for the entry type and depth.
module crpd_queue import crpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ofs_t wdata,
	input  logic pop,
	output ofs_t head,
	output logic full,
	output logic empty
);

	ofs_t             mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QPtrW:0]   count_q;

	assign full  = (count_q == (QPtrW+1)'(QDepth));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

// File: hdl/crpd_back.sv
// Back end: basis combination, normalising shift, squared length, root and
// rounded division, then the output register. Depends on crpd_pkg.
module crpd_back import crpd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  ofs_t                   head,
	input  logic                   q_empty,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [OutW-1:0] dir_x,
	output logic signed [OutW-1:0] dir_y,
	output logic signed [OutW-1:0] dir_z
);

	logic en;
	logic [12:1] vld_s;
	logic out_valid_q;
	logic signed [OutW-1:0] dir_q [3];

	logic signed [33:0] rp_s1 [3];
	logic signed [33:0] up_s1 [3];
	logic signed [34:0] a_s2 [3];
	logic signed [47:0] pl_s3 [3];
	logic signed [47:0] ph_s3 [3];
	logic signed [60:0] d_s4 [3];
	logic [MagW-1:0] mag_s5 [3];
	logic [2:0] neg_s5;
	logic [MagW-1:0] mag_s6 [3];
	logic [MagW-1:0] all_s6;
	tag_t tag_s6, tag_s7, tag_s8, tag_s9, tag_s10, tag_s11, tag_s12;
	logic [MagW-1:0] mag_s7 [3];
	logic [7:0] gnz_s7;
	logic [7:0][2:0] glz_s7;
	logic [5:0] lz_c;
	logic [MagW-1:0] mag_s8 [3];
	logic [5:0] lz_s8;
	logic [MagW-1:0] mag_s9 [3];
	logic [2:0] lz_s9;
	logic [2:0][NrmW-1:0] nm_s10, nm_s11, nm_s12;
	logic [2*NrmW-1:0] sq_s11 [3];
	logic [61:0] sum_s12;

	logic [RootW-1:0]     rt_rem_s [RootIters+1];
	logic [RootW-1:0]     rt_res_s [RootIters+1];
	logic [2:0][NrmW-1:0] rt_nm_s  [RootIters+1];
	tag_t                 rt_tag_s [RootIters+1];
	logic [RootIters:0]   rt_vld_s;

	logic [2:0][NumW-1:0] dv_num_s [QuoW+1];
	logic [2:0][QuoW-1:0] dv_quo_s [QuoW+1];
	logic [30:0]          dv_q_s   [QuoW+1];
	tag_t                 dv_tag_s [QuoW+1];
	logic [QuoW:0]        dv_vld_s;
	logic [30:0]          root;

	logic [63:0] all64;

	assign en  = !out_valid_q || !out_stall;
	assign pop = en && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[11:1], pop};
		end
	end

	assign all64 = {all_s6, 6'b0};

	always_comb begin
		lz_c = '0;
		for (int g = 0; g < 8; g++) begin
			if (gnz_s7[g]) lz_c = {3'(7 - g), glz_s7[g]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				rp_s1[k] <= head.tx * comp_of(cfg.right, 2'(k));
				up_s1[k] <= head.ty * comp_of(cfg.up, 2'(k));
				a_s2[k]  <= rp_s1[k] + up_s1[k];
				pl_s3[k] <= a_s2[k] * $signed({1'b0, cfg.scale[11:0]});
				ph_s3[k] <= a_s2[k] * $signed({1'b0, cfg.scale[23:12]});
				d_s4[k]  <= (comp_of(cfg.fwd, 2'(k)) <<< 20) + pl_s3[k] + (ph_s3[k] <<< 12);
				neg_s5[k] <= d_s4[k][60];
				mag_s5[k] <= d_s4[k][60] ? MagW'(-d_s4[k]) : d_s4[k][MagW-1:0];
				mag_s6[k] <= mag_s5[k];
				mag_s7[k] <= mag_s6[k];
				mag_s8[k] <= mag_s7[k];
				mag_s9[k] <= mag_s8[k] << {lz_s8[5:3], 3'b0};
				nm_s10[k] <= NrmW'(MagW'(mag_s9[k] << lz_s9) >> (MagW - NrmW));
				sq_s11[k] <= nm_s10[k] * nm_s10[k];
			end
			all_s6      <= mag_s5[0] | mag_s5[1] | mag_s5[2];
			tag_s6.neg  <= neg_s5;
			tag_s6.zero <= (mag_s5[0] | mag_s5[1] | mag_s5[2]) == '0;
			for (int g = 0; g < 8; g++) begin
				gnz_s7[g] <= |all64[8*g +: 8];
				glz_s7[g] <= lz8(all64[8*g +: 8]);
			end
			tag_s7  <= tag_s6;
			lz_s8   <= lz_c;
			tag_s8  <= tag_s7;
			lz_s9   <= lz_s8[2:0];
			tag_s9  <= tag_s8;
			tag_s10 <= tag_s9;
			nm_s11  <= nm_s10;
			tag_s11 <= tag_s10;
			sum_s12 <= 62'(sq_s11[0]) + 62'(sq_s11[1]) + 62'(sq_s11[2]);
			nm_s12  <= nm_s11;
			tag_s12 <= tag_s11;
		end
	end

	assign rt_rem_s[0] = RootW'(sum_s12);
	assign rt_res_s[0] = '0;
	assign rt_nm_s[0]  = nm_s12;
	assign rt_tag_s[0] = tag_s12;
	assign rt_vld_s[0] = vld_s[12];

	for (genvar i = 0; i < RootIters; i++) begin : g_root
		localparam logic [RootW-1:0] Bit = RootW'(1) << (62 - 2 * i);
		logic [RootW-1:0] trial;
		logic             ge;
		assign trial = rt_res_s[i] + Bit;
		assign ge    = rt_rem_s[i] >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[i+1] <= 1'b0;
			end else if (en) begin
				rt_vld_s[i+1] <= rt_vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem_s[i+1] <= ge ? rt_rem_s[i] - trial : rt_rem_s[i];
				rt_res_s[i+1] <= ge ? (rt_res_s[i] >> 1) + Bit : rt_res_s[i] >> 1;
				rt_nm_s[i+1]  <= rt_nm_s[i];
				rt_tag_s[i+1] <= rt_tag_s[i];
			end
		end
	end

	assign root = rt_res_s[RootIters][30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (en) begin
			dv_vld_s[0] <= rt_vld_s[RootIters];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dv_num_s[0][k] <= NumW'({rt_nm_s[RootIters][k], 16'b0}) + NumW'(root >> 1);
			end
			dv_quo_s[0] <= '0;
			dv_q_s[0]   <= root;
			dv_tag_s[0] <= rt_tag_s[RootIters];
		end
	end

	for (genvar j = 0; j < QuoW; j++) begin : g_div
		localparam int Sh = QuoW - 1 - j;
		logic [NumW:0] dq;
		logic [2:0]    ge;
		assign dq = (NumW+1)'(dv_q_s[j]) << Sh;
		for (genvar k = 0; k < 3; k++) begin : g_lane
			assign ge[k] = {1'b0, dv_num_s[j][k]} >= dq;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[j+1] <= dv_vld_s[j];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 3; k++) begin
					dv_num_s[j+1][k] <= ge[k] ? NumW'({1'b0, dv_num_s[j][k]} - dq)
						: dv_num_s[j][k];
					dv_quo_s[j+1][k] <= {dv_quo_s[j][k][QuoW-2:0], ge[k]};
				end
				dv_q_s[j+1]   <= dv_q_s[j];
				dv_tag_s[j+1] <= dv_tag_s[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_vld_s[QuoW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				if (dv_tag_s[QuoW].zero)
					dir_q[k] <= '0;
				else if (dv_tag_s[QuoW].neg[k])
					dir_q[k] <= -$signed(OutW'(dv_quo_s[QuoW][k]));
				else
					dir_q[k] <= $signed(OutW'(dv_quo_s[QuoW][k]));
			end
		end
	end

	assign out_valid = out_valid_q;
	assign dir_x     = dir_q[0];
	assign dir_y     = dir_q[1];
	assign dir_z     = dir_q[2];

endmodule

// File: hdl/crpd_checker.sv
// Port-level checks for the primary ray block, bound to the top level.
// Depends on crpd_pkg for widths.
module crpd_checker import crpd_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   pready,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic signed [OutW-1:0] dir_x,
	input logic signed [OutW-1:0] dir_y,
	input logic signed [OutW-1:0] dir_z
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(dir_x) && $stable(dir_y) && $stable(dir_z))
		else $error("stalled result changed");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> dir_x >= -18'sd65536 && dir_x <= 18'sd65536
			&& dir_y >= -18'sd65536 && dir_y <= 18'sd65536
			&& dir_z >= -18'sd65536 && dir_z <= 18'sd65536)
		else $error("direction component beyond unit range");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind camera_primary_ray_direction crpd_checker u_chk (.*);

// File: test/camera_primary_ray_direction_tb.sv
`timescale 1ns / 1ps
// Testbench for camera_primary_ray_direction: APB register set-up, random pixel
// stream with gaps and stalls, scoreboard with its own ray direction predictor.
// Depends on crpd_pkg and the block's RTL.
module camera_primary_ray_direction_tb;
	import crpd_pkg::*;

	localparam int WatchLimit = 20000;

	typedef struct {
		logic signed [OutW-1:0] x;
		logic signed [OutW-1:0] y;
		logic signed [OutW-1:0] z;
	} ray_t;

	class ray_scoreboard;
		logic [DimW-1:0]   width;
		logic [DimW-1:0]   height;
		logic [ScaleW-1:0] scale;
		logic [VecW-1:0]   fwd;
		logic [VecW-1:0]   right;
		logic [VecW-1:0]   up;
		ray_t              pending[$];
		int                errors;

		function new();
			width = RstWidth;
			height = RstHeight;
			scale = RstScale;
			fwd = RstFwd;
			right = RstRight;
			up = RstUp;
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [63:0] val);
			case (idx)
				REG_WIDTH: width = val[DimW-1:0];
				REG_HEIGHT: height = val[DimW-1:0];
				REG_SCALE: scale = val[ScaleW-1:0];
				REG_FORWARD: fwd = val[VecW-1:0];
				REG_RIGHT: right = val[VecW-1:0];
				REG_UP: up = val[VecW-1:0];
				default: ;
			endcase
		endfunction

		function longint vec_part(logic [VecW-1:0] v, int k);
			logic [CompBits-1:0] f;
			f = v[k*CompBits +: CompBits];
			return longint'($signed(f));
		endfunction

		function longint unsigned isqrt(longint unsigned s);
			longint unsigned res, bt;
			res = 0;
			bt = 64'd1 << 62;
			for (int i = 0; i < 32; i++) begin
				if (s >= res + bt) begin
					s = s - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
			return res;
		endfunction

		function void note_pixel(logic [PixW-1:0] col, logic [PixW-1:0] row);
			longint w, h, s, px, py, d;
			longint unsigned mag[3], all, sum, q, o;
			logic neg[3];
			logic signed [OutW-1:0] res[3];
			int msb;
			ray_t r;
			w = (width > MaxDim) ? MaxDim : width;
			h = (height > MaxDim) ? MaxDim : height;
			s = scale;
			px = (2 * longint'(col) + 1 - w) * s;
			py = (h - 2 * longint'(row) - 1) * s;
			all = 0;
			sum = 0;
			msb = 0;
			for (int k = 0; k < 3; k++) begin
				d = vec_part(fwd, k) * (64'sd1 <<< 20) + px * vec_part(right, k)
					+ py * vec_part(up, k);
				neg[k] = d < 0;
				mag[k] = neg[k] ? -d : d;
				all |= mag[k];
			end
			if (all == 0) begin
				r.x = '0;
				r.y = '0;
				r.z = '0;
				pending.push_back(r);
				return;
			end
			for (int b = 0; b < 64; b++)
				if (all[b]) msb = b;
			for (int k = 0; k < 3; k++) begin
				if (msb > 29) mag[k] = mag[k] >> (msb - 29);
				else mag[k] = mag[k] << (29 - msb);
				sum += mag[k] * mag[k];
			end
			q = isqrt(sum);
			for (int k = 0; k < 3; k++) begin
				o = (mag[k] * 65536 + (q >> 1)) / q;
				if (o > 65536) o = 65536;
				res[k] = neg[k] ? -OutW'(o) : OutW'(o);
			end
			r.x = res[0];
			r.y = res[1];
			r.z = res[2];
			pending.push_back(r);
		endfunction

		function void check_ray(logic signed [OutW-1:0] x, logic signed [OutW-1:0] y,
			logic signed [OutW-1:0] z);
			ray_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected ray %0d %0d %0d", $time, x, y, z);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (x !== e.x) begin
				$display("%0t: dir_x expected %0d actual %0d", $time, e.x, x);
				errors++;
			end
			if (y !== e.y) begin
				$display("%0t: dir_y expected %0d actual %0d", $time, e.y, y);
				errors++;
			end
			if (z !== e.z) begin
				$display("%0t: dir_z expected %0d actual %0d", $time, e.z, z);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   psel, penable, pwrite;
	logic [AddrW-1:0]       paddr;
	logic [DataW-1:0]       pwdata;
	logic [DataW-1:0]       prdata;
	logic                   pready;
	logic                   in_valid, in_stall;
	logic [PixW-1:0]        pixel_col, pixel_row;
	logic                   out_valid, out_stall;
	logic signed [OutW-1:0] dir_x, dir_y, dir_z;

	ray_scoreboard sb;
	int  idle_cycles;
	bit  hold_off;
	bit  stim_done;
	bit  press_req;
	bit  press_done;

	camera_primary_ray_direction u_dut (.*);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AddrW'(8 * int'(idx));
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic send_pixel(logic [PixW-1:0] col, logic [PixW-1:0] row, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_col <= col;
		pixel_row <= row;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_pixel(col, row);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [VecW-1:0] rand_vec(bit full);
		logic [VecW-1:0] v;
		for (int k = 0; k < 3; k++)
			v[k*CompBits +: CompBits] = full ? CompBits'($urandom)
				: CompBits'($signed($urandom_range(524288)) - 262144);
		return v;
	endfunction

	task automatic random_setting(int mode);
		logic [12:0] w, h;
		case (mode)
			0: begin
				w = 13'd1;
				h = 13'd1;
			end
			1: begin
				w = 13'h1FFF;
				h = 13'd0;
			end
			default: begin
				w = 13'($urandom_range(4096, 1));
				h = 13'($urandom_range(4096, 1));
			end
		endcase
		write_reg(REG_WIDTH, 64'(w));
		write_reg(REG_HEIGHT, 64'(h));
		write_reg(REG_SCALE, mode == 1 ? 64'hFFFFFF : (mode == 0 ? 64'd0
			: 64'($urandom_range(8192))));
		write_reg(REG_FORWARD, mode == 0 ? 64'd0 : 64'(rand_vec(mode == 1)));
		write_reg(REG_RIGHT, mode == 0 ? 64'd0 : 64'(rand_vec(mode == 1)));
		write_reg(REG_UP, 64'(rand_vec(mode == 1)));
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		pixel_col = '0;
		pixel_row = '0;
		stim_done = 1'b0;
		press_req = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_pixel(12'd0, 12'd0, 0);
		send_pixel(12'd511, 12'd511, 0);
		send_pixel(12'd255, 12'd256, 0);
		send_pixel(12'hFFF, 12'hFFF, 0);
		send_pixel(12'hFFF, 12'd0, 0);
		send_pixel(12'd0, 12'hFFF, 0);
		drain();
		random_setting(0);
		send_pixel(12'd0, 12'd0, 0);
		send_pixel(12'hFFF, 12'hFFF, 0);
		drain();
		write_reg(REG_UP, 64'd0);
		send_pixel(12'd7, 12'd3, 0);
		drain();
		random_setting(1);
		send_pixel(12'd0, 12'd0, 0);
		send_pixel(12'hFFF, 12'hFFF, 0);
		send_pixel(12'h800, 12'h7FF, 0);
		drain();
		write_reg(REG_WIDTH, 64'd4096);
		write_reg(REG_HEIGHT, 64'd4096);
		send_pixel(12'd2048, 12'd2047, 0);
		send_pixel(12'h555, 12'hAAA, 0);
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			random_setting(ph == 7 ? 1 : 2);
			if (ph == 3) press_req = 1'b1;
			for (int i = 0; i < 200; i++) begin
				if ($urandom_range(9) == 0)
					send_pixel(12'($urandom), 12'($urandom), 1);
				else
					send_pixel(12'($urandom_range(int'(sb.width) > 4096 ? 4095
						: int'(sb.width) - 1)), 12'($urandom_range(int'(sb.height) > 4096
						? 4095 : int'(sb.height) - 1)), ph != 3);
			end
			drain();
		end
		stim_done = 1'b1;
		if (sb.errors == 0)
			$display("camera_primary_ray_direction verification clean");
		else
			$display("camera_primary_ray_direction verification failed");
		$finish;
	end

	initial begin
		int g;
		out_stall = 1'b1;
		hold_off = 1'b0;
		press_done = 1'b0;
		@(posedge arst_n);
		forever begin
			g = gap_len();
			if (!hold_off && stim_done == 0
				&& ((press_req && !press_done) || $urandom_range(299) == 0)) begin
				if (press_req) press_done = 1'b1;
				hold_off = 1'b1;
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end else if (g > 0 && $urandom_range(2) == 0) begin
				out_stall <= 1'b1;
				repeat (g) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(20, 1)) @(posedge clk);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_ray(dir_x, dir_y, dir_z);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("camera_primary_ray_direction verification failed");
			$finish;
		end
	end

	initial idle_cycles = 0;

endmodule
